/* rtl/core/scuv_pkg.sv */
// ----------------------------------------------------------------------------
// scuv_pkg
// Shared widths, register indexes and the CORDIC arctangent table of the
// spherical/cylindrical texture coordinate generator.
// ----------------------------------------------------------------------------
`default_nettype none

package scuv_pkg;

   localparam int POS_W      = 16;
   localparam int TEX_W      = 32;
   localparam int SCALE_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_LEN          = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE    = 2'd0,
      CSR_U_SCALE = 2'd1,
      CSR_V_SCALE = 2'd2
   } csr_idx_type;

   // atan(2^-k) in units of 2^-32 of a full turn.
   function automatic logic [31:0] atan_entry(input int unsigned k);
      logic [31:0] r;
      case (k)
         0:  r = 32'd536870912;
         1:  r = 32'd316933406;
         2:  r = 32'd167458907;
         3:  r = 32'd85004756;
         4:  r = 32'd42667331;
         5:  r = 32'd21354465;
         6:  r = 32'd10679838;
         7:  r = 32'd5340245;
         8:  r = 32'd2670163;
         9:  r = 32'd1335087;
         10: r = 32'd667544;
         11: r = 32'd333772;
         12: r = 32'd166886;
         13: r = 32'd83443;
         14: r = 32'd41722;
         15: r = 32'd20861;
         16: r = 32'd10430;
         17: r = 32'd5215;
         18: r = 32'd2608;
         19: r = 32'd1304;
         20: r = 32'd652;
         21: r = 32'd326;
         22: r = 32'd163;
         23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/scuv_chan_if.sv */
// ----------------------------------------------------------------------------
// scuv channel interfaces
// Valid/ready channels for vertex requests and texture coordinate responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface scuv_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [scuv_pkg::POS_W-1:0] pos_x;
   logic signed [scuv_pkg::POS_W-1:0] pos_y;
   logic signed [scuv_pkg::POS_W-1:0] pos_z;

   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface scuv_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [scuv_pkg::TEX_W-1:0] tex_u;
   logic signed [scuv_pkg::TEX_W-1:0] tex_v;

   modport source (output valid, tex_u, tex_v, input ready);
   modport sink   (input valid, tex_u, tex_v, output ready);
endinterface

`default_nettype wire

/* rtl/core/sphere_cylinder_uv_mapping.sv */
// ----------------------------------------------------------------------------
// sphere_cylinder_uv_mapping
// Turns a local vertex into spherical or cylindrical texture coordinates.
// ----------------------------------------------------------------------------
// The block accepts one vertex per clock while the output is not stalled
// and returns its (u, v) pair through the square root of the horizontal
// length, which resolves one root bit per stage over 30 stages, followed
// by the CORDIC stages that run the u and v angle vectorings side by side,
// plus three input stages and two output stages.
// All stages move together: the pipe advances whenever the output register
// is empty or its transaction is taken, so a stalled response freezes the
// whole pipe and nothing is lost or repeated.
`default_nettype none

module sphere_cylinder_uv_mapping #(
   parameter int CORDIC_STAGES = scuv_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   scuv_req_if.sink                              req_chan,
   scuv_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_wr_en,
   input  wire logic [scuv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [scuv_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import scuv_pkg::*;

   localparam int SQB = 30;          // root bits
   localparam int RW  = 62;          // square root remainder
   localparam int CW  = 34;          // CORDIC coordinates
   localparam int AW  = 36;          // angles
   localparam int PW  = AW + SCALE_W + 1;
   localparam int NS  = CORDIC_STAGES;

   localparam logic signed [AW-1:0] HALF_TURN    = AW'(64'sd2147483648);
   localparam logic signed [AW-1:0] QUARTER_TURN = AW'(64'sd1073741824);

   typedef struct packed {
      logic signed [POS_W-1:0] y;
      logic signed [CW-1:0]    ux;
      logic signed [CW-1:0]    uz;
      logic signed [AW-1:0]    ubase;
      logic                    uzero;
      logic [29:0]             cq;
      logic                    cneg;
   } hold_type;

   typedef struct packed {
      logic        uzero;
      logic        hzero;
      logic        ypos;
      logic        yneg;
      logic [29:0] cq;
      logic        cneg;
   } tail_type;

   // Configuration registers.
   logic              mode_ff;
   logic [SCALE_W-1:0] u_scale_ff;
   logic [SCALE_W-1:0] v_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b1;
         u_scale_ff <= SCALE_W'(256);
         v_scale_ff <= SCALE_W'(256);
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_MODE:    mode_ff    <= csr_wdata[0];
            CSR_U_SCALE: u_scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_V_SCALE: v_scale_ff <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;

   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Stage 1: squares and the cylindrical product.
   logic                    s1_valid_ff;
   logic signed [POS_W-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic [30:0]             s1_xx_ff, s1_zz_ff;
   logic signed [32:0]      s1_p_ff;
   logic signed [31:0]      sq_x_in, sq_z_in;
   logic signed [32:0]      p_in;

   always_comb begin
      sq_x_in = req_chan.pos_x * req_chan.pos_x;
      sq_z_in = req_chan.pos_z * req_chan.pos_z;
      p_in    = 33'(req_chan.pos_y) * 33'(signed'({1'b0, v_scale_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff  <= req_chan.pos_x;
         s1_y_ff  <= req_chan.pos_y;
         s1_z_ff  <= req_chan.pos_z;
         s1_xx_ff <= sq_x_in[30:0];
         s1_zz_ff <= sq_z_in[30:0];
         s1_p_ff  <= p_in;
      end
   end

   // Stage 2: horizontal square length; cylindrical v reduced to a floor
   // division by three of a sign and magnitude.
   logic                    s2_valid_ff;
   logic signed [POS_W-1:0] s2_x_ff, s2_y_ff, s2_z_ff;
   logic [31:0]             s2_hsq_ff;
   logic                    s2_cneg_ff;
   logic [31:0]             s2_cmag_ff;
   logic signed [36:0]      cyl_m;
   logic signed [36:0]      cyl_a;
   logic [31:0]             cmag_in;

   always_comb begin
      cyl_m   = 37'(signed'({1'b0, v_scale_ff})) * 37'sd6144 - 37'(s1_p_ff) * 37'sd5
                + 37'sd24;
      cyl_a   = cyl_m >>> 4;
      // floor(a/3) for negative a equals -floor((2 - a)/3).
      cmag_in = cyl_a[36] ? 32'(37'sd2 - cyl_a) : 32'(cyl_a);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_z_ff    <= s1_z_ff;
         s2_hsq_ff  <= 32'(s1_xx_ff) + 32'(s1_zz_ff);
         s2_cneg_ff <= cyl_a[36];
         s2_cmag_ff <= cmag_in;
      end
   end

   // Stage 3: radicand, u vector folded into the right half plane, and the
   // division by three as a reciprocal multiply.
   logic              s3_valid_ff;
   hold_type          s3_hold_ff;
   logic [RW-1:0]     s3_rad_ff;
   hold_type          hold_in;
   logic signed [CW-1:0] cx, cz;
   logic [63:0]       qprod;

   always_comb begin
      cx    = CW'(s2_x_ff) <<< 14;
      cz    = CW'(s2_z_ff) <<< 14;
      qprod = {32'b0, s2_cmag_ff} * 64'h0000_0000_AAAA_AAAB;
      hold_in.y     = s2_y_ff;
      hold_in.ux    = s2_x_ff[POS_W-1] ? -cx : cx;
      hold_in.uz    = s2_x_ff[POS_W-1] ? -cz : cz;
      if (!s2_x_ff[POS_W-1]) begin
         hold_in.ubase = '0;
      end else if (!s2_z_ff[POS_W-1]) begin
         hold_in.ubase = HALF_TURN;
      end else begin
         hold_in.ubase = -HALF_TURN;
      end
      hold_in.uzero = (s2_x_ff == '0) && (s2_z_ff == '0);
      hold_in.cq    = qprod[62:33];
      hold_in.cneg  = s2_cneg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_hold_ff <= hold_in;
         s3_rad_ff  <= {2'b0, s2_hsq_ff, 28'b0};
      end
   end

   // Square root, one root bit per stage.
   logic           sq_valid_ff [SQB];
   hold_type       sq_hold_ff  [SQB];
   logic [RW-1:0]  sq_rem_ff   [SQB];
   logic [SQB-1:0] sq_root_ff  [SQB];

   for (genvar j = 0; j < SQB; j++) begin : g_sqrt
      localparam int BIT = SQB - 1 - j;
      logic           pv;
      hold_type       ph;
      logic [RW-1:0]  prem;
      logic [SQB-1:0] proot;
      logic [RW-1:0]  trial;

      if (j == 0) begin : g_first
         assign pv    = s3_valid_ff;
         assign ph    = s3_hold_ff;
         assign prem  = s3_rad_ff;
         assign proot = '0;
      end else begin : g_next
         assign pv    = sq_valid_ff[j-1];
         assign ph    = sq_hold_ff[j-1];
         assign prem  = sq_rem_ff[j-1];
         assign proot = sq_root_ff[j-1];
      end

      assign trial = (RW'(proot) << (BIT + 1)) + (RW'(1) << (2 * BIT));

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[j] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_hold_ff[j] <= ph;
            if (prem >= trial) begin
               sq_rem_ff[j]  <= prem - trial;
               sq_root_ff[j] <= proot | (SQB'(1) << BIT);
            end else begin
               sq_rem_ff[j]  <= prem;
               sq_root_ff[j] <= proot;
            end
         end
      end
   end

   // Vectoring CORDIC stages, u and v side by side.
   logic                 cd_valid_ff [NS];
   logic signed [CW-1:0] cd_ux_ff    [NS];
   logic signed [CW-1:0] cd_uy_ff    [NS];
   logic signed [AW-1:0] cd_ua_ff    [NS];
   logic signed [CW-1:0] cd_vx_ff    [NS];
   logic signed [CW-1:0] cd_vy_ff    [NS];
   logic signed [AW-1:0] cd_va_ff    [NS];
   tail_type             cd_tail_ff  [NS];

   for (genvar k = 0; k < NS; k++) begin : g_cordic
      logic                 pv;
      logic signed [CW-1:0] pux, puy, pvx, pvy;
      logic signed [AW-1:0] pua, pva;
      tail_type             pt;
      logic signed [AW-1:0] step;

      if (k == 0) begin : g_first
         hold_type lh;
         assign lh    = sq_hold_ff[SQB-1];
         assign pv    = sq_valid_ff[SQB-1];
         assign pux   = lh.ux;
         assign puy   = lh.uz;
         assign pua   = lh.ubase;
         assign pvx   = signed'(CW'(sq_root_ff[SQB-1]));
         assign pvy   = CW'(lh.y) <<< 14;
         assign pva   = '0;
         assign pt.uzero = lh.uzero;
         assign pt.hzero = (sq_root_ff[SQB-1] == '0);
         assign pt.ypos  = !lh.y[POS_W-1] && (lh.y != '0);
         assign pt.yneg  = lh.y[POS_W-1];
         assign pt.cq    = lh.cq;
         assign pt.cneg  = lh.cneg;
      end else begin : g_next
         assign pv  = cd_valid_ff[k-1];
         assign pux = cd_ux_ff[k-1];
         assign puy = cd_uy_ff[k-1];
         assign pua = cd_ua_ff[k-1];
         assign pvx = cd_vx_ff[k-1];
         assign pvy = cd_vy_ff[k-1];
         assign pva = cd_va_ff[k-1];
         assign pt  = cd_tail_ff[k-1];
      end

      assign step = signed'(AW'(atan_entry(k)));

      always_ff @(posedge clock) begin
         if (reset) begin
            cd_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            cd_valid_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cd_tail_ff[k] <= pt;
            if (!puy[CW-1]) begin
               cd_ux_ff[k] <= pux + (puy >>> k);
               cd_uy_ff[k] <= puy - (pux >>> k);
               cd_ua_ff[k] <= pua + step;
            end else begin
               cd_ux_ff[k] <= pux - (puy >>> k);
               cd_uy_ff[k] <= puy + (pux >>> k);
               cd_ua_ff[k] <= pua - step;
            end
            if (!pvy[CW-1]) begin
               cd_vx_ff[k] <= pvx + (pvy >>> k);
               cd_vy_ff[k] <= pvy - (pvx >>> k);
               cd_va_ff[k] <= pva + step;
            end else begin
               cd_vx_ff[k] <= pvx - (pvy >>> k);
               cd_vy_ff[k] <= pvy + (pvx >>> k);
               cd_va_ff[k] <= pva - step;
            end
         end
      end
   end

   // Scale stage: turn fractions times the Q8.8 scales.
   logic                  f_valid_ff;
   logic signed [PW-1:0]  f_pu_ff, f_pv_ff;
   logic signed [TEX_W-1:0] f_cv_ff;
   logic                  f_mode_ff;
   tail_type              lt;
   logic signed [AW-1:0]  fu, fv, va_eff;
   logic signed [TEX_W-1:0] cv_in;

   always_comb begin
      lt = cd_tail_ff[NS-1];
      fu = lt.uzero ? HALF_TURN : HALF_TURN + cd_ua_ff[NS-1];
      if (!lt.hzero) begin
         va_eff = cd_va_ff[NS-1];
      end else if (lt.ypos) begin
         va_eff = QUARTER_TURN;
      end else if (lt.yneg) begin
         va_eff = -QUARTER_TURN;
      end else begin
         va_eff = '0;
      end
      fv    = HALF_TURN - (va_eff <<< 1);
      cv_in = lt.cneg ? -signed'(TEX_W'(lt.cq)) : signed'(TEX_W'(lt.cq));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= cd_valid_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_pu_ff   <= PW'(fu) * PW'(signed'({1'b0, u_scale_ff}));
         f_pv_ff   <= PW'(fv) * PW'(signed'({1'b0, v_scale_ff}));
         f_cv_ff   <= cv_in;
         f_mode_ff <= mode_ff;
      end
   end

   // Output register: round half up to Q16.16. The scaled values stay well
   // inside the 32-bit range, so no clamp is needed.
   logic signed [TEX_W-1:0] tex_u_ff, tex_v_ff;
   logic signed [PW-1:0]    ru, rv;

   always_comb begin
      ru = (f_pu_ff + PW'(64'sd8388608)) >>> 24;
      rv = (f_pv_ff + PW'(64'sd8388608)) >>> 24;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tex_u_ff <= TEX_W'(ru);
         tex_v_ff <= f_mode_ff ? TEX_W'(rv) : f_cv_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.tex_u = tex_u_ff;
   assign rsp_chan.tex_v = tex_v_ff;

endmodule

`default_nettype wire

/* rtl/core/scuv_checker.sv */
// ----------------------------------------------------------------------------
// scuv_checker
// Port-level checks of the texture coordinate generator.
// ----------------------------------------------------------------------------
`default_nettype none

module scuv_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] tex_u,
   input wire logic [31:0] tex_v
);

   // The pipe moves as one: input is taken exactly when the output moves.
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not track the output stall");

   // Reset empties the pipe.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(tex_u) && $stable(tex_v))
      else $error("stalled response changed");

   // A response is not dropped while the pipe is frozen.
   a_no_rise_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind sphere_cylinder_uv_mapping scuv_checker u_scuv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .tex_u     (rsp_chan.tex_u),
   .tex_v     (rsp_chan.tex_v)
);

`default_nettype wire
